### rtl/stack_machine_alu_top_macros.svh
// Assertion macros shared by the stack machine RTL.
`ifndef STACK_MACHINE_ALU_TOP_MACROS_SVH
`define STACK_MACHINE_ALU_TOP_MACROS_SVH

// Clocked property check, held off while reset is asserted.
`define SMA_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define SMA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

### rtl/sma_pkg.sv
// Shared constants and types of the stack machine ALU.
`default_nettype none

package sma_pkg;

    localparam int unsigned STACK_DEPTH = 64;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
    localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int unsigned FUNC_W      = 3;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned DEPTH_OUT_W = 7;
    localparam int unsigned STEP_W      = $clog2(DATA_W);

    typedef logic signed [DATA_W-1:0]   t_data;
    typedef logic        [DATA_W-1:0]   t_udata;
    typedef logic        [ADDR_W-1:0]   t_addr;
    typedef logic        [CNT_W-1:0]    t_count;
    typedef logic        [FUNC_W-1:0]   t_func;
    typedef logic        [STATUS_W-1:0] t_status;
    typedef logic        [DEPTH_OUT_W-1:0] t_depth_out;
    typedef logic        [STEP_W-1:0]   t_div_step;

    // Operation codes
    localparam t_func FUNC_NOP  = 3'd0;
    localparam t_func FUNC_PUSH = 3'd1;
    localparam t_func FUNC_SWAP = 3'd2;
    localparam t_func FUNC_ADD  = 3'd3;
    localparam t_func FUNC_SUB  = 3'd4;
    localparam t_func FUNC_DIV  = 3'd5;

    // Status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_SHORT = 2'd1;
    localparam t_status ST_ZERO  = 2'd2;
    localparam t_status ST_FULL  = 2'd3;

endpackage

`default_nettype wire

### rtl/sma_stack_ram.sv
// Single-port-write, single-port-read synchronous RAM holding the stack entries.
`default_nettype none

module sma_stack_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/sma_divider.sv
// Radix-2 restoring divider, signed, truncating toward zero, one quotient bit per cycle.
`default_nettype none

module sma_divider (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire sma_pkg::t_data i_dividend,
    input  wire sma_pkg::t_data i_divisor,
    output logic               o_done,
    output sma_pkg::t_data     o_quotient
);

    logic                  r_busy;
    logic                  r_fin;
    sma_pkg::t_div_step    r_step;
    sma_pkg::t_udata       r_rem;
    sma_pkg::t_udata       r_quo;
    sma_pkg::t_udata       r_dvs;
    logic                  r_neg;

    logic [sma_pkg::DATA_W:0] shifted;
    logic [sma_pkg::DATA_W:0] trial;
    sma_pkg::t_udata          n_rem;
    sma_pkg::t_udata          n_quo;

    // one restoring step: shift in next dividend bit, try subtract
    always_comb begin
        shifted = {r_rem, r_quo[sma_pkg::DATA_W-1]};
        trial   = shifted - {1'b0, r_dvs};
        if (!trial[sma_pkg::DATA_W]) begin
            n_rem = trial[sma_pkg::DATA_W-1:0];
            n_quo = {r_quo[sma_pkg::DATA_W-2:0], 1'b1};
        end else begin
            n_rem = shifted[sma_pkg::DATA_W-1:0];
            n_quo = {r_quo[sma_pkg::DATA_W-2:0], 1'b0};
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_step <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + sma_pkg::t_div_step'(1);
                if (r_step == sma_pkg::t_div_step'(sma_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    // datapath: magnitudes on start, then iterate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[sma_pkg::DATA_W-1] ? sma_pkg::t_udata'(-i_dividend)
                                                   : sma_pkg::t_udata'(i_dividend);
            r_dvs <= i_divisor[sma_pkg::DATA_W-1] ? sma_pkg::t_udata'(-i_divisor)
                                                  : sma_pkg::t_udata'(i_divisor);
            r_neg <= i_dividend[sma_pkg::DATA_W-1] ^ i_divisor[sma_pkg::DATA_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // sign fix-up; the minimum over minus one wraps to itself
    assign o_quotient = r_neg ? sma_pkg::t_data'(-r_quo) : sma_pkg::t_data'(r_quo);
    assign o_done     = r_fin;

endmodule

`default_nettype wire

### rtl/stack_machine_alu_top.sv
// Stack machine ALU top level: sequencer over the stack RAM and the serial divider.
//
//  channel   dir  handshake                   payload
//  -------   ---  --------------------------  ----------------------------------------
//  command   in   i_in_valid / o_in_ready     i_func, i_push_value
//  result    out  o_out_valid / i_out_ready   o_status, o_top_value, o_stack_depth
//
//  Nop, push and any error go straight to the response; add and sub first read the
//  second entry, swap then writes back the old top, div waits on 32 one-bit steps.
//  One transaction is in work at a time; the top entry is cached in a register
//  and the second entry comes from the RAM through its registered read port.
//  Reset empties the stack at once; RAM contents stay undefined and need no clearing.
//  A stalled result waits in the output register while the next command is taken.
`default_nettype none

`include "stack_machine_alu_top_macros.svh"

module stack_machine_alu_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire sma_pkg::t_func   i_func,
    input  wire sma_pkg::t_data   i_push_value,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output sma_pkg::t_status      o_status,
    output sma_pkg::t_data        o_top_value,
    output sma_pkg::t_depth_out   o_stack_depth
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SWAP2,
        S_DIV,
        S_RESP
    } t_state;

    t_state                r_state,  n_state;
    sma_pkg::t_count       r_count,  n_count;
    sma_pkg::t_func        r_func,   n_func;
    sma_pkg::t_data        r_top,    n_top;
    sma_pkg::t_data        r_hold,   n_hold;
    sma_pkg::t_status      r_status, n_status;
    logic                  r_out_valid, n_out_valid;
    sma_pkg::t_status      r_o_status, n_o_status;
    sma_pkg::t_data        r_o_top,    n_o_top;
    sma_pkg::t_depth_out   r_o_depth,  n_o_depth;

    logic                  in_acc;
    logic                  ram_we;
    sma_pkg::t_addr        ram_waddr;
    sma_pkg::t_data        ram_wdata;
    logic                  ram_re;
    sma_pkg::t_data        ram_rdata;
    sma_pkg::t_addr        top_addr;
    sma_pkg::t_addr        sec_addr;
    logic                  div_start;
    logic                  div_done;
    sma_pkg::t_data        div_q;

    sma_stack_ram #(
        .DEPTH (sma_pkg::STACK_DEPTH),
        .WIDTH (sma_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (sec_addr),
        .o_rdata (ram_rdata)
    );

    sma_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ram_rdata),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign top_addr   = sma_pkg::t_addr'(r_count - sma_pkg::t_count'(1));
    assign sec_addr   = sma_pkg::t_addr'(r_count - sma_pkg::t_count'(2));

    // sequencer: decode, read second entry, modify, write back
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_func      = r_func;
        n_top       = r_top;
        n_hold      = r_hold;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_top     = r_o_top;
        n_o_depth   = r_o_depth;
        ram_we      = 1'b0;
        ram_waddr   = sec_addr;
        ram_wdata   = r_top;
        ram_re      = 1'b0;
        div_start   = 1'b0;

        // result taken by the consumer
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_func   = i_func;
                    n_status = sma_pkg::ST_OK;
                    n_state  = S_RESP;
                    case (i_func)
                        sma_pkg::FUNC_PUSH: begin
                            if (r_count >= sma_pkg::t_count'(sma_pkg::STACK_DEPTH)) begin
                                n_status = sma_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = sma_pkg::t_addr'(r_count);
                                ram_wdata = i_push_value;
                                n_top     = i_push_value;
                                n_count   = r_count + sma_pkg::t_count'(1);
                            end
                        end
                        sma_pkg::FUNC_SWAP, sma_pkg::FUNC_ADD,
                        sma_pkg::FUNC_SUB, sma_pkg::FUNC_DIV: begin
                            if (r_count < sma_pkg::t_count'(2)) begin
                                n_status = sma_pkg::ST_SHORT;
                            end else if (i_func == sma_pkg::FUNC_DIV && r_top == '0) begin
                                n_status = sma_pkg::ST_ZERO;
                            end else begin
                                ram_re  = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            // nop and unused codes leave the stack alone
                        end
                    endcase
                end
            end
            S_READ: begin
                case (r_func)
                    sma_pkg::FUNC_SWAP: begin
                        ram_we    = 1'b1;
                        ram_waddr = top_addr;
                        ram_wdata = ram_rdata;
                        n_hold    = r_top;
                        n_top     = ram_rdata;
                        n_state   = S_SWAP2;
                    end
                    sma_pkg::FUNC_ADD: begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata + r_top;
                        n_top     = ram_rdata + r_top;
                        n_count   = r_count - sma_pkg::t_count'(1);
                        n_state   = S_RESP;
                    end
                    sma_pkg::FUNC_SUB: begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata - r_top;
                        n_top     = ram_rdata - r_top;
                        n_count   = r_count - sma_pkg::t_count'(1);
                        n_state   = S_RESP;
                    end
                    default: begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                endcase
            end
            S_SWAP2: begin
                // old top goes to the second slot
                ram_we    = 1'b1;
                ram_wdata = r_hold;
                n_state   = S_RESP;
            end
            S_DIV: begin
                if (div_done) begin
                    ram_we    = 1'b1;
                    ram_wdata = div_q;
                    n_top     = div_q;
                    n_count   = r_count - sma_pkg::t_count'(1);
                    n_state   = S_RESP;
                end
            end
            S_RESP: begin
                // load the output register once it is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_top     = (r_count != '0) ? r_top : '0;
                    n_o_depth   = sma_pkg::t_depth_out'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, stack pointer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_func     <= n_func;
        r_top      <= n_top;
        r_hold     <= n_hold;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_top    <= n_o_top;
        r_o_depth  <= n_o_depth;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_top_value   = r_o_top;
    assign o_stack_depth = r_o_depth;

    // checks
    `SMA_NEVER(a_count_range, r_count > sma_pkg::t_count'(sma_pkg::STACK_DEPTH), "stack count beyond depth")
    `SMA_NEVER(a_ram_rw_overlap, ram_we && ram_re, "RAM read and write in the same cycle")
    `SMA_CHECK(a_div_done_in_div, div_done |-> (r_state == S_DIV), "divider finished outside div wait")
    `SMA_CHECK(a_resp_loads_out, (r_state == S_RESP && n_state == S_IDLE) |=> r_out_valid, "result not registered")

endmodule

`default_nettype wire

### tb/stack_machine_alu_top_test.sv
// Self-checking testbench for the stack machine ALU top level.
`timescale 1ns / 1ps

module stack_machine_alu_top_test;

    localparam int unsigned WATCHDOG_LIMIT   = 3000;
    localparam int unsigned DRAIN_CYCLES     = 60;
    localparam int unsigned LONG_HOLD_CYCLES = 240;
    localparam int unsigned ITEMS_PER_PHASE  = 320;

    // Shape of a burst of random commands
    typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} t_burst_mode;

    typedef struct {
        sma_pkg::t_status    status;
        sma_pkg::t_data      top;
        sma_pkg::t_depth_out depth;
    } t_stack_result;

    // Stack predictor plus queue of expected results
    class t_stack_result_book;
        sma_pkg::t_udata stack_cells [sma_pkg::STACK_DEPTH];
        int unsigned     entry_total;
        t_stack_result   pending_results[$];
        int unsigned     failures;
        int unsigned     commands_noted;
        int unsigned     results_checked;
        int unsigned     status_tally [4];
        int unsigned     deepest;

        function new();
            entry_total     = 0;
            failures        = 0;
            commands_noted  = 0;
            results_checked = 0;
            deepest         = 0;
            foreach (status_tally[k]) status_tally[k] = 0;
        endfunction

        task report_mismatch(string what);
            $display("%0t ns  mismatch: %s", $time, what);
            failures++;
        endtask

        // Apply one accepted command to the predicted stack
        function void note_command(sma_pkg::t_func func, sma_pkg::t_data push_value);
            t_stack_result   res;
            sma_pkg::t_udata top_entry, second_entry, mag_a, mag_b, quot;
            logic            neg_a, neg_b;
            res.status = sma_pkg::ST_OK;
            if (func == sma_pkg::FUNC_PUSH) begin
                if (entry_total >= sma_pkg::STACK_DEPTH) begin
                    res.status = sma_pkg::ST_FULL;
                end else begin
                    stack_cells[entry_total] = push_value;
                    entry_total++;
                end
            end else if (func >= sma_pkg::FUNC_SWAP && func <= sma_pkg::FUNC_DIV) begin
                if (entry_total < 2) begin
                    res.status = sma_pkg::ST_SHORT;
                end else begin
                    top_entry    = stack_cells[entry_total - 1];
                    second_entry = stack_cells[entry_total - 2];
                    case (func)
                        sma_pkg::FUNC_SWAP: begin
                            stack_cells[entry_total - 1] = second_entry;
                            stack_cells[entry_total - 2] = top_entry;
                        end
                        sma_pkg::FUNC_ADD: begin
                            stack_cells[entry_total - 2] = second_entry + top_entry;
                            entry_total--;
                        end
                        sma_pkg::FUNC_SUB: begin
                            stack_cells[entry_total - 2] = second_entry - top_entry;
                            entry_total--;
                        end
                        default: begin
                            if (top_entry == '0) begin
                                res.status = sma_pkg::ST_ZERO;
                            end else begin
                                // truncating divide on magnitudes; min / -1 wraps
                                neg_a = second_entry[sma_pkg::DATA_W-1];
                                neg_b = top_entry[sma_pkg::DATA_W-1];
                                mag_a = neg_a ? -second_entry : second_entry;
                                mag_b = neg_b ? -top_entry : top_entry;
                                quot  = mag_a / mag_b;
                                stack_cells[entry_total - 2] = (neg_a != neg_b) ? -quot : quot;
                                entry_total--;
                            end
                        end
                    endcase
                end
            end
            res.top   = (entry_total > 0) ? sma_pkg::t_data'(stack_cells[entry_total - 1]) : '0;
            res.depth = sma_pkg::t_depth_out'(entry_total);
            pending_results.push_back(res);
            status_tally[res.status]++;
            commands_noted++;
            if (entry_total > deepest) deepest = entry_total;
        endfunction

        // Compare one accepted result against the oldest expectation
        task check_result(sma_pkg::t_status status, sma_pkg::t_data top,
                          sma_pkg::t_depth_out depth);
            t_stack_result want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: status %0d top %0d depth %0d",
                                          status, top, depth));
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (status !== want.status)
                report_mismatch($sformatf("result %0d status %0d, want %0d",
                                          results_checked, status, want.status));
            if (top !== want.top)
                report_mismatch($sformatf("result %0d top %0d, want %0d",
                                          results_checked, top, want.top));
            if (depth !== want.depth)
                report_mismatch($sformatf("result %0d depth %0d, want %0d",
                                          results_checked, depth, want.depth));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    sma_pkg::t_func      i_func;
    sma_pkg::t_data      i_push_value;
    logic                o_out_valid;
    logic                i_out_ready;
    sma_pkg::t_status    o_status;
    sma_pkg::t_data      o_top_value;
    sma_pkg::t_depth_out o_stack_depth;

    t_stack_result_book book;
    int unsigned        send_idle_pct;
    int unsigned        recv_stall_pct;
    logic               long_hold_req;
    int unsigned        hold_left;
    int unsigned        quiet_cycles;

    stack_machine_alu_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_push_value  (i_push_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_top_value   (o_top_value),
        .o_stack_depth (o_stack_depth)
    );

    // Clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Known values on every input from time zero
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_func         = sma_pkg::FUNC_NOP;
        i_push_value   = '0;
        i_out_ready    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  = 1'b0;
        hold_left      = 0;
        quiet_cycles   = 0;
        book           = new();
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            hold_left     = LONG_HOLD_CYCLES;
            long_hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left--;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            book.check_result(o_status, o_top_value, o_stack_depth);
    end

    // Cycles without any transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t ns  no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("stack_machine_alu_top regression: fail");
        $finish;
    end

    // Offer one command and hold it until the block takes it
    task automatic send_command(input sma_pkg::t_func func, input sma_pkg::t_data push_value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_func       = func;
        i_push_value = push_value;
        do @(posedge i_clk); while (!o_in_ready);
        book.note_command(func, push_value);
    endtask

    initial begin : stimulus
        int unsigned    phase;
        int unsigned    n;
        int unsigned    burst_left;
        int unsigned    push_pct;
        int unsigned    pick;
        t_burst_mode    mode;
        sma_pkg::t_func func;
        sma_pkg::t_data value;

        burst_left = 0;
        mode       = MODE_MIX;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: errors on an empty stack, wraps, operand order, zero divisor
        send_command(sma_pkg::FUNC_NOP,  sma_pkg::t_data'(0));
        send_command(sma_pkg::FUNC_ADD,  sma_pkg::t_data'(0));
        send_command(sma_pkg::FUNC_SWAP, sma_pkg::t_data'(0));
        send_command(sma_pkg::FUNC_DIV,  sma_pkg::t_data'(0));
        send_command(sma_pkg::FUNC_SUB,  sma_pkg::t_data'(0));
        send_command(sma_pkg::FUNC_PUSH, 32'sh7FFF_FFFF);
        send_command(sma_pkg::FUNC_PUSH, sma_pkg::t_data'(1));
        send_command(sma_pkg::FUNC_ADD,  sma_pkg::t_data'(0));    // max + 1 wraps to min
        send_command(sma_pkg::FUNC_PUSH, sma_pkg::t_data'(1));
        send_command(sma_pkg::FUNC_SUB,  sma_pkg::t_data'(0));    // min - 1 wraps to max
        send_command(sma_pkg::FUNC_PUSH, sma_pkg::t_data'(0));
        send_command(sma_pkg::FUNC_DIV,  sma_pkg::t_data'(0));    // zero divisor
        send_command(sma_pkg::FUNC_SWAP, sma_pkg::t_data'(0));
        send_command(sma_pkg::FUNC_DIV,  sma_pkg::t_data'(0));    // 0 / max
        send_command(sma_pkg::FUNC_PUSH, 32'sh8000_0000);
        send_command(sma_pkg::FUNC_PUSH, sma_pkg::t_data'(-1));
        send_command(sma_pkg::FUNC_DIV,  sma_pkg::t_data'(0));    // min / -1 wraps
        send_command(sma_pkg::FUNC_PUSH, sma_pkg::t_data'(-7));
        send_command(sma_pkg::FUNC_PUSH, sma_pkg::t_data'(2));
        send_command(sma_pkg::FUNC_DIV,  sma_pkg::t_data'(0));    // truncates toward zero
        send_command(sma_pkg::FUNC_PUSH, sma_pkg::t_data'(5));
        send_command(sma_pkg::FUNC_PUSH, sma_pkg::t_data'(3));
        send_command(sma_pkg::FUNC_SUB,  sma_pkg::t_data'(0));    // second minus top
        send_command(sma_pkg::t_func'(6), 32'sh5555_AAAA);        // unused codes act as nop
        send_command(sma_pkg::t_func'(7), 32'shAAAA_5555);

        // Random bursts under four pacing regimes
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // back up the result side while commands keep coming
                if (phase == 0 && n == ITEMS_PER_PHASE / 2)
                    long_hold_req = 1'b1;
                if (burst_left == 0) begin
                    pick = $urandom_range(3);
                    mode = (pick == 2) ? MODE_FILL : (pick == 3) ? MODE_DRAIN : MODE_MIX;
                    burst_left = (mode == MODE_FILL) ? 90 : 24;
                end
                burst_left--;
                push_pct = (mode == MODE_FILL)  ? 90 :
                           (mode == MODE_DRAIN) ? 10 :
                           (book.entry_total < 4) ? 60 : 40;
                pick = $urandom_range(99);
                if (pick < push_pct)
                    func = sma_pkg::FUNC_PUSH;
                else if (pick >= 95)
                    func = sma_pkg::t_func'($urandom_range(7));
                else
                    func = sma_pkg::t_func'($urandom_range(sma_pkg::FUNC_DIV, sma_pkg::FUNC_SWAP));
                pick = $urandom_range(9);
                if (pick < 5) begin
                    value = sma_pkg::t_data'($urandom);
                end else if (pick < 8) begin
                    value = sma_pkg::t_data'(int'($urandom_range(200)) - 100);
                end else begin
                    case ($urandom_range(4))
                        0: value = sma_pkg::t_data'(0);
                        1: value = sma_pkg::t_data'(1);
                        2: value = sma_pkg::t_data'(-1);
                        3: value = 32'sh8000_0000;
                        default: value = 32'sh7FFF_FFFF;
                    endcase
                end
                send_command(func, value);
            end
        end

        // Let every outstanding result drain
        @(negedge i_clk);
        i_in_valid     = 1'b0;
        recv_stall_pct = 0;
        while (book.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.pending_results.size() != 0)
            book.report_mismatch($sformatf("%0d results never arrived",
                                           book.pending_results.size()));

        $display("Ran %0d commands through four pacing regimes and one long output hold; %0d results checked.",
                 book.commands_noted, book.results_checked);
        $display("Statuses: ok %0d, short %0d, zero divisor %0d, full %0d; deepest stack %0d.",
                 book.status_tally[sma_pkg::ST_OK], book.status_tally[sma_pkg::ST_SHORT],
                 book.status_tally[sma_pkg::ST_ZERO], book.status_tally[sma_pkg::ST_FULL],
                 book.deepest);
        if (book.failures == 0)
            $display("stack_machine_alu_top regression: pass");
        else
            $display("stack_machine_alu_top regression: fail");
        $finish;
    end

endmodule
